[src/mstlw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstlw_pkg
// Shared constants and types for the spanning-forest leftover weight block.
// ----------------------------------------------------------------------------
package mstlw_pkg;

	localparam int MAX_EDGES    = 4096;
	localparam int MAX_VERTICES = 1024;
	localparam int EDGE_AW      = $clog2(MAX_EDGES);
	localparam int CNT_W        = EDGE_AW + 1;
	localparam int VTX_W        = $clog2(MAX_VERTICES);
	localparam int VCNT_W       = VTX_W + 1;
	localparam int WGT_W        = 16;
	localparam int SUM_W        = 28;
	localparam int RANK_W       = 4;

	localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
	localparam logic [RANK_W-1:0] RANK_MAX = {RANK_W{1'b1}};

	// weight in the top bits so a plain compare orders by weight, then src, dst
	typedef struct packed {
		logic [WGT_W-1:0] weight;
		logic [VTX_W-1:0] src;
		logic [VTX_W-1:0] dst;
	} edge_t;

endpackage

[src/max_spanning_tree_leftover_weight.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_spanning_tree_leftover_weight
// Stores one edge per word; on the last edge clears the union-find tables,
// merge-sorts the edges by descending weight and runs Kruskal, summing the
// weights of cycle-closing edges.
// ----------------------------------------------------------------------------
// Operation: edge words are taken while idle. After the last edge of a set the
//   union-find tables are cleared, the edges are merge-sorted, then each edge runs
//   its two finds and path-compression walks and a join.
// Sets: one set at a time; input stalls from the last edge until the
//   result is posted. Reset clears control state; edge and set tables are rebuilt per set.
module max_spanning_tree_leftover_weight (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mstlw_pkg::VCNT_W-1:0]    vertex_count,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [mstlw_pkg::VTX_W-1:0]     src_vertex,
	input  logic [mstlw_pkg::VTX_W-1:0]     dst_vertex,
	input  logic [mstlw_pkg::WGT_W-1:0]     edge_weight,
	input  logic                            last_edge,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [mstlw_pkg::SUM_W-1:0]     leftover_weight,
	output logic                            bad_vertex_seen
);

	localparam int CW = mstlw_pkg::CNT_W;
	localparam int AW = mstlw_pkg::EDGE_AW;
	localparam int VW = mstlw_pkg::VTX_W;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CLR, ST_SORT_INIT, ST_S_BLK, ST_S_RD, ST_S_WR,
		ST_K_INIT, ST_K_RD, ST_K_GET, ST_F_RD, ST_F_CHK, ST_C_RD, ST_C_CHK,
		ST_JOIN, ST_DONE
	} state_t;

	state_t state_q;

	logic [mstlw_pkg::VCNT_W-1:0] vcount_q;
	logic [CW-1:0]                edge_total_q;
	logic                         bad_q;
	logic [mstlw_pkg::SUM_W-1:0]  sum_q;
	logic [VW:0]                  clr_q;

	// sort pointers
	logic [CW-1:0] width_q, lo_q, mid_q, hi_q, i_q, j_q, k_q;
	logic          src_sel_q;

	// union-find walk
	logic [VW-1:0]                 uf_addr_q, root_q, ra_q, va_q, vb_q;
	logic [mstlw_pkg::RANK_W-1:0]  rank_a_q, rank_root_q;
	logic [mstlw_pkg::WGT_W-1:0]   ew_q;
	logic                          phase_q;

	logic                          out_valid_q;
	logic [mstlw_pkg::SUM_W-1:0]   out_sum_q;
	logic                          out_bad_q;

	// edge memories (ping-pong for the merge passes)
	mstlw_pkg::edge_t mem_a [mstlw_pkg::MAX_EDGES];
	mstlw_pkg::edge_t mem_b [mstlw_pkg::MAX_EDGES];
	mstlw_pkg::edge_t a_rd_i_q, a_rd_j_q, b_rd_i_q, b_rd_j_q;
	logic             a_we, b_we;
	logic [AW-1:0]    a_waddr, b_waddr;
	mstlw_pkg::edge_t a_wdata, b_wdata;

	// union-find tables
	logic [VW-1:0]                par_mem  [mstlw_pkg::MAX_VERTICES];
	logic [mstlw_pkg::RANK_W-1:0] rank_mem [mstlw_pkg::MAX_VERTICES];
	logic [VW-1:0]                par_rd_q;
	logic [mstlw_pkg::RANK_W-1:0] rank_rd_q;
	logic                         par_we, rank_we;
	logic [VW-1:0]                par_waddr, par_wdata, rank_waddr;
	logic [mstlw_pkg::RANK_W-1:0] rank_wdata;

	logic in_acc, in_ok;
	mstlw_pkg::edge_t in_edge, rd_i, rd_j, pick;
	logic             take_i, i_live, j_live, merge_more;
	logic [CW:0]      lo_w, mid_c, mid_w, hi_c;
	logic [CW:0]      width_dbl;
	logic [mstlw_pkg::SUM_W:0] sum_ext;
	logic             a_gt_b;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign in_ok     = ({1'b0, src_vertex} < vcount_q) && ({1'b0, dst_vertex} < vcount_q);
	assign in_edge   = '{weight: edge_weight, src: src_vertex, dst: dst_vertex};

	assign out_valid       = out_valid_q;
	assign leftover_weight = out_sum_q;
	assign bad_vertex_seen = out_bad_q;

	assign rd_i = src_sel_q ? b_rd_i_q : a_rd_i_q;
	assign rd_j = src_sel_q ? b_rd_j_q : a_rd_j_q;

	assign i_live     = (i_q < mid_q);
	assign j_live     = (j_q < hi_q);
	assign merge_more = i_live || j_live;
	assign take_i     = i_live && (!j_live || (rd_i >= rd_j));
	assign pick       = take_i ? rd_i : rd_j;

	assign lo_w      = {1'b0, lo_q} + {1'b0, width_q};
	assign mid_c     = (lo_w > {1'b0, edge_total_q}) ? {1'b0, edge_total_q} : lo_w;
	assign mid_w     = mid_c + {1'b0, width_q};
	assign hi_c      = (mid_w > {1'b0, edge_total_q}) ? {1'b0, edge_total_q} : mid_w;
	assign width_dbl = {width_q, 1'b0};

	assign sum_ext = {1'b0, sum_q} + {{(mstlw_pkg::SUM_W + 1 - mstlw_pkg::WGT_W){1'b0}}, ew_q};
	assign a_gt_b  = (rank_a_q > rank_root_q);

	// memory write steering
	always_comb begin
		a_we       = 1'b0;
		b_we       = 1'b0;
		a_waddr    = edge_total_q[AW-1:0];
		b_waddr    = k_q[AW-1:0];
		a_wdata    = in_edge;
		b_wdata    = pick;
		par_we     = 1'b0;
		rank_we    = 1'b0;
		par_waddr  = uf_addr_q;
		par_wdata  = root_q;
		rank_waddr = root_q;
		rank_wdata = rank_root_q + 1'b1;
		case (state_q)
			ST_IDLE: begin
				a_we = in_acc && in_ok && (edge_total_q < CW'(mstlw_pkg::MAX_EDGES));
			end
			ST_S_WR: begin
				a_we    = src_sel_q;
				b_we    = !src_sel_q;
				a_waddr = k_q[AW-1:0];
				a_wdata = pick;
			end
			ST_CLR: begin
				par_we     = 1'b1;
				rank_we    = 1'b1;
				par_waddr  = clr_q[VW-1:0];
				par_wdata  = clr_q[VW-1:0];
				rank_waddr = clr_q[VW-1:0];
				rank_wdata = '0;
			end
			ST_C_CHK: begin
				par_we = (par_rd_q != root_q);
			end
			ST_JOIN: begin
				if (ra_q != root_q) begin
					par_we     = 1'b1;
					par_waddr  = a_gt_b ? root_q : ra_q;
					par_wdata  = a_gt_b ? ra_q : root_q;
					// equal ranks: the surviving root (the second one) grows
					rank_we    = (rank_a_q == rank_root_q) && (rank_root_q != mstlw_pkg::RANK_MAX);
					rank_waddr = root_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (a_we) begin
			mem_a[a_waddr] <= a_wdata;
		end
		a_rd_i_q <= mem_a[i_q[AW-1:0]];
		a_rd_j_q <= mem_a[j_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (b_we) begin
			mem_b[b_waddr] <= b_wdata;
		end
		b_rd_i_q <= mem_b[i_q[AW-1:0]];
		b_rd_j_q <= mem_b[j_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (par_we) begin
			par_mem[par_waddr] <= par_wdata;
		end
		par_rd_q <= par_mem[uf_addr_q];
	end

	always_ff @(posedge clk) begin
		if (rank_we) begin
			rank_mem[rank_waddr] <= rank_wdata;
		end
		rank_rd_q <= rank_mem[uf_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			vcount_q     <= mstlw_pkg::VCNT_W'(mstlw_pkg::MAX_VERTICES);
			edge_total_q <= '0;
			bad_q        <= 1'b0;
			sum_q        <= '0;
			clr_q        <= '0;
			width_q      <= '0;
			lo_q         <= '0;
			mid_q        <= '0;
			hi_q         <= '0;
			i_q          <= '0;
			j_q          <= '0;
			k_q          <= '0;
			src_sel_q    <= 1'b0;
			uf_addr_q    <= '0;
			root_q       <= '0;
			ra_q         <= '0;
			va_q         <= '0;
			vb_q         <= '0;
			rank_a_q     <= '0;
			rank_root_q  <= '0;
			ew_q         <= '0;
			phase_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			out_sum_q    <= '0;
			out_bad_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				vcount_q <= vertex_count;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (!in_ok) begin
							bad_q <= 1'b1;
						end else if (edge_total_q < CW'(mstlw_pkg::MAX_EDGES)) begin
							edge_total_q <= edge_total_q + 1'b1;
						end
						if (last_edge) begin
							clr_q   <= '0;
							state_q <= ST_CLR;
						end
					end
				end
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (VW+1)'(mstlw_pkg::MAX_VERTICES - 1)) begin
						state_q <= ST_SORT_INIT;
					end
				end
				ST_SORT_INIT: begin
					width_q   <= CW'(1);
					lo_q      <= '0;
					src_sel_q <= 1'b0;
					state_q   <= (edge_total_q > CW'(1)) ? ST_S_BLK : ST_K_INIT;
				end
				ST_S_BLK: begin
					if (lo_q >= edge_total_q) begin
						// pass done: output side becomes the next source
						src_sel_q <= !src_sel_q;
						width_q   <= width_dbl[CW-1:0];
						lo_q      <= '0;
						if (width_dbl >= {1'b0, edge_total_q}) begin
							state_q <= ST_K_INIT;
						end
					end else begin
						mid_q   <= mid_c[CW-1:0];
						hi_q    <= hi_c[CW-1:0];
						i_q     <= lo_q;
						j_q     <= mid_c[CW-1:0];
						k_q     <= lo_q;
						state_q <= ST_S_RD;
					end
				end
				ST_S_RD: begin
					if (merge_more) begin
						state_q <= ST_S_WR;
					end else begin
						lo_q    <= hi_q;
						state_q <= ST_S_BLK;
					end
				end
				ST_S_WR: begin
					if (take_i) begin
						i_q <= i_q + 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
					end
					k_q     <= k_q + 1'b1;
					state_q <= ST_S_RD;
				end
				ST_K_INIT: begin
					i_q     <= '0;
					sum_q   <= '0;
					state_q <= (edge_total_q == '0) ? ST_DONE : ST_K_RD;
				end
				ST_K_RD: begin
					state_q <= ST_K_GET;
				end
				ST_K_GET: begin
					ew_q      <= rd_i.weight;
					va_q      <= rd_i.src;
					vb_q      <= rd_i.dst;
					uf_addr_q <= rd_i.src;
					phase_q   <= 1'b0;
					state_q   <= ST_F_RD;
				end
				ST_F_RD: begin
					state_q <= ST_F_CHK;
				end
				ST_F_CHK: begin
					if (par_rd_q == uf_addr_q) begin
						root_q      <= uf_addr_q;
						rank_root_q <= rank_rd_q;
						uf_addr_q   <= phase_q ? vb_q : va_q;
						state_q     <= ST_C_RD;
					end else begin
						uf_addr_q <= par_rd_q;
						state_q   <= ST_F_RD;
					end
				end
				ST_C_RD: begin
					state_q <= ST_C_CHK;
				end
				ST_C_CHK: begin
					if (par_rd_q == root_q) begin
						if (!phase_q) begin
							ra_q      <= root_q;
							rank_a_q  <= rank_root_q;
							phase_q   <= 1'b1;
							uf_addr_q <= vb_q;
							state_q   <= ST_F_RD;
						end else begin
							state_q <= ST_JOIN;
						end
					end else begin
						uf_addr_q <= par_rd_q;
						state_q   <= ST_C_RD;
					end
				end
				ST_JOIN: begin
					if (ra_q == root_q) begin
						sum_q <= sum_ext[mstlw_pkg::SUM_W] ? mstlw_pkg::SUM_MAX
						                                   : sum_ext[mstlw_pkg::SUM_W-1:0];
					end
					i_q     <= i_q + 1'b1;
					state_q <= ((i_q + 1'b1) == edge_total_q) ? ST_DONE : ST_K_RD;
				end
				ST_DONE: begin
					if (!out_valid_q) begin
						out_valid_q  <= 1'b1;
						out_sum_q    <= sum_q;
						out_bad_q    <= bad_q;
						edge_total_q <= '0;
						bad_q        <= 1'b0;
						sum_q        <= '0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// a result word appears only on leaving the final state
	ast_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result posted outside done state");

	ast_edge_total_cap: assert property (@(posedge clk) disable iff (!arst_n)
		edge_total_q <= CW'(mstlw_pkg::MAX_EDGES))
		else $error("edge count above store depth");

	ast_merge_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_S_WR) |-> (k_q < hi_q) && (i_q <= mid_q) && (j_q <= hi_q))
		else $error("merge pointer out of block");

	ast_sum_only_kruskal: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (sum_q == '0))
		else $error("leftover sum not cleared between sets");

endmodule

[tb/max_spanning_tree_leftover_weight_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_spanning_tree_leftover_weight_tb
// Feeds edge sets under several vertex counts and random idling on both sides.
// Each set result is checked against a Kruskal forest sum computed in the bench.
// ----------------------------------------------------------------------------
module max_spanning_tree_leftover_weight_tb;

	class forest_scoreboard;
		int unsigned limit_vtx = mstlw_pkg::MAX_VERTICES;
		logic [35:0] edge_keys[$];
		bit dropped_seen;
		logic [mstlw_pkg::SUM_W-1:0] exp_sum[$];
		bit exp_bad[$];
		int errors;
		int parent[mstlw_pkg::MAX_VERTICES];
		int rank_of[mstlw_pkg::MAX_VERTICES];

		function void set_vertex_count(int unsigned vc);
			limit_vtx = (vc < mstlw_pkg::MAX_VERTICES) ? vc : mstlw_pkg::MAX_VERTICES;
		endfunction

		function int find_root(int v);
			int r;
			int nxt;
			r = v;
			while (parent[r] != r) r = parent[r];
			while (parent[v] != r) begin
				nxt = parent[v];
				parent[v] = r;
				v = nxt;
			end
			return r;
		endfunction

		function void note_edge(int unsigned s, int unsigned d, int unsigned w, bit last);
			logic [mstlw_pkg::SUM_W:0] acc;
			int ra;
			int rb;
			int t;
			if (s >= limit_vtx || d >= limit_vtx)
				dropped_seen = 1;
			else if (edge_keys.size() < mstlw_pkg::MAX_EDGES)
				edge_keys.push_back({w[15:0], s[9:0], d[9:0]});
			if (!last)
				return;
			for (int i = 0; i < mstlw_pkg::MAX_VERTICES; i++) begin
				parent[i] = i;
				rank_of[i] = 0;
			end
			edge_keys.rsort();
			acc = 0;
			foreach (edge_keys[i]) begin
				ra = find_root(edge_keys[i][19:10]);
				rb = find_root(edge_keys[i][9:0]);
				if (ra == rb) begin
					acc = acc + edge_keys[i][35:20];
					if (acc > mstlw_pkg::SUM_MAX) acc = mstlw_pkg::SUM_MAX;
				end else begin
					if (rank_of[ra] > rank_of[rb]) begin
						t = ra; ra = rb; rb = t;
					end
					parent[ra] = rb;
					if (rank_of[ra] == rank_of[rb] && rank_of[rb] < mstlw_pkg::RANK_MAX)
						rank_of[rb]++;
				end
			end
			exp_sum.push_back(acc[mstlw_pkg::SUM_W-1:0]);
			exp_bad.push_back(dropped_seen);
			edge_keys.delete();
			dropped_seen = 0;
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check(logic [mstlw_pkg::SUM_W-1:0] lw, logic bad);
			if (exp_sum.size() == 0) begin
				report($sformatf("unexpected result %0d/%0b", lw, bad));
				return;
			end
			if (lw !== exp_sum[0])
				report($sformatf("leftover_weight %0d, want %0d", lw, exp_sum[0]));
			if (bad !== exp_bad[0])
				report($sformatf("bad_vertex_seen %0b, want %0b", bad, exp_bad[0]));
			void'(exp_sum.pop_front());
			void'(exp_bad.pop_front());
		endtask

		function int pending();
			return exp_sum.size();
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [mstlw_pkg::VCNT_W-1:0]   vertex_count;
	logic                           in_valid;
	logic                           in_stall;
	logic [mstlw_pkg::VTX_W-1:0]    src_vertex;
	logic [mstlw_pkg::VTX_W-1:0]    dst_vertex;
	logic [mstlw_pkg::WGT_W-1:0]    edge_weight;
	logic                           last_edge;
	logic                           out_valid;
	logic                           out_stall;
	logic [mstlw_pkg::SUM_W-1:0]    leftover_weight;
	logic                           bad_vertex_seen;

	forest_scoreboard sb = new();
	int tx_idle_pct;
	int rx_idle_pct;
	int cur_limit;
	int item_count;

	max_spanning_tree_leftover_weight dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .vertex_count(vertex_count),
		.in_valid(in_valid), .in_stall(in_stall),
		.src_vertex(src_vertex), .dst_vertex(dst_vertex),
		.edge_weight(edge_weight), .last_edge(last_edge),
		.out_valid(out_valid), .out_stall(out_stall),
		.leftover_weight(leftover_weight), .bad_vertex_seen(bad_vertex_seen)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check(leftover_weight, bad_vertex_seen);
		out_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	task automatic send_edge(int unsigned s, int unsigned d, int unsigned w, bit last);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		src_vertex  <= mstlw_pkg::VTX_W'(s);
		dst_vertex  <= mstlw_pkg::VTX_W'(d);
		edge_weight <= mstlw_pkg::WGT_W'(w);
		last_edge   <= last;
		do @(posedge clk); while (in_stall);
		sb.note_edge(s, d, w, last);
		item_count++;
	endtask

	// write vertex_count once every result is back and the block has settled
	task automatic write_vertex_count(int unsigned vc);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_valid    <= 1'b1;
		vertex_count <= mstlw_pkg::VCNT_W'(vc);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_vertex_count(vc);
		cur_limit = (vc < mstlw_pkg::MAX_VERTICES) ? vc : mstlw_pkg::MAX_VERTICES;
	endtask

	function automatic int unsigned pick_vertex(int span);
		if (cur_limit == 0 || $urandom_range(19) == 0)
			return $urandom_range(1023);
		return $urandom_range(span - 1);
	endfunction

	task automatic random_set();
		int n;
		int span;
		int unsigned w;
		n = ($urandom_range(9) == 0) ? $urandom_range(60, 13) : $urandom_range(12, 1);
		span = (cur_limit == 0) ? 1 : $urandom_range(cur_limit, 1);
		if (span > 8 && $urandom_range(1) == 0) span = $urandom_range(8, 1);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(3))
				0: w = $urandom_range(15);
				1: w = 16'hFFFF - $urandom_range(3);
				default: w = $urandom_range(16'hFFFF);
			endcase
			send_edge(pick_vertex(span), pick_vertex(span), w, i == n - 1);
		end
	endtask

	initial begin
		int unsigned vc_list[9] = '{1, 1024, 0, 2047, 16, 5, 1023, 64, 2};
		cfg_valid <= 1'b0;
		vertex_count <= '0;
		in_valid <= 1'b0;
		src_vertex <= '0;
		dst_vertex <= '0;
		edge_weight <= '0;
		last_edge <= 1'b0;
		tx_idle_pct = 24;
		rx_idle_pct = 68;
		cur_limit = mstlw_pkg::MAX_VERTICES;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, self loops, ties, a lone edge
		send_edge(0, 0, 16'hFFFF, 0);
		send_edge(1023, 1023, 0, 0);
		send_edge(0, 1023, 16'hFFFF, 0);
		send_edge(1023, 0, 16'hFFFF, 0);
		send_edge(512, 511, 1, 0);
		send_edge(511, 512, 1, 0);
		send_edge(341, 682, 16'h5555, 0);
		send_edge(682, 341, 16'hAAAA, 1);
		send_edge(7, 9, 100, 1);
		send_edge(3, 3, 42, 1);
		write_vertex_count(4);
		send_edge(5, 0, 9, 1);            // empty set: only a dropped edge
		send_edge(0, 1, 10, 0);
		send_edge(1, 2, 20, 0);
		send_edge(2, 0, 30, 0);
		send_edge(3, 4, 40, 0);
		send_edge(3, 0, 5, 1);

		for (int p = 0; p < 9; p++) begin
			tx_idle_pct = (p < 3) ? 24 : (p < 6) ? 68 : 0;
			rx_idle_pct = (p < 3) ? 68 : (p < 6) ? 24 : 0;
			write_vertex_count(vc_list[p]);
			while (item_count < 17 + 48 * (p + 1)) random_set();
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end

endmodule

[sim.f]
src/mstlw_pkg.sv
src/max_spanning_tree_leftover_weight.sv
tb/max_spanning_tree_leftover_weight_tb.sv
